// ----- rtl/core/tccw_pkg.sv -----
// Shared constants, codes and types for the text console character writer.
// No dependencies; used by every module in rtl/core but tccw_ram, and by the testbench.
`default_nettype none

package tccw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);

  // Field widths
  localparam int OP_W   = 2;
  localparam int CHR_W  = 8;
  localparam int IDX_W  = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = COL_W + ROW_W;
  localparam int CLR_W  = 4;
  localparam int ATTR_W = 2 * CLR_W;
  localparam int CELL_W = ATTR_W + CHR_W;

  localparam int IN_TDATA_W  = ((CHR_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = COL_W + ROW_W + CHR_W + ATTR_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Operations
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Control characters
  localparam logic [CHR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHR_W-1:0] CH_SPACE = 8'h20;

  localparam int TAB_STOP = 4;
  localparam logic [COL_W:0] TAB_MASK = ~((COL_W + 1)'(TAB_STOP - 1));

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [CLR_W-1:0]  RESET_FG   = 4'hF;
  localparam logic [CLR_W-1:0]  RESET_BG   = 4'h0;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_COPY,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CHR_W-1:0] chr;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CHR_W-1:0]  chr;
    logic [ATTR_W-1:0] attr;
    logic              scrolled;
  } result_t;

  // Cursor step for one put-character item
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              wr;
    logic [ADDR_W-1:0] pos;
    logic              scroll;
  } move_t;

endpackage

`default_nettype wire

// ----- rtl/core/tccw_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Generic; no package dependency.
`default_nettype none

module tccw_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tccw_cursor.sv -----
// Cursor step for a put-character item: control codes, wrap and scroll
// detection, and the cell address of a printable byte. Uses tccw_pkg.
`default_nettype none

module tccw_cursor (
  input  wire logic [tccw_pkg::COL_W-1:0] col,
  input  wire logic [tccw_pkg::ROW_W-1:0] row,
  input  wire logic [tccw_pkg::CHR_W-1:0] chr,
  output tccw_pkg::move_t                 mv
);

  always_comb begin
    logic [tccw_pkg::COL_W:0]   c;
    logic [tccw_pkg::ROW_W:0]   r;
    logic [tccw_pkg::POS_W-1:0] pos;
    logic                       printable;
    logic                       scroll;

    c         = {1'b0, col};
    r         = {1'b0, row};
    printable = 1'b0;
    case (chr)
      tccw_pkg::CH_LF: begin
        c = '0;
        r = r + 1'b1;
      end
      tccw_pkg::CH_CR: begin
        c = '0;
      end
      tccw_pkg::CH_TAB: begin
        c = (c + (tccw_pkg::COL_W + 1)'(tccw_pkg::TAB_STOP)) & tccw_pkg::TAB_MASK;
      end
      tccw_pkg::CH_BS: begin
        if (c != '0) begin
          c = c - 1'b1;
        end
      end
      default: begin
        c         = c + 1'b1;
        printable = 1'b1;
      end
    endcase

    if (c >= (tccw_pkg::COL_W + 1)'(tccw_pkg::COLUMNS)) begin
      c = '0;
      r = r + 1'b1;
    end

    // only ever one row past the bottom
    scroll = (r >= (tccw_pkg::ROW_W + 1)'(tccw_pkg::ROWS));
    if (scroll) begin
      r = (tccw_pkg::ROW_W + 1)'(tccw_pkg::ROWS - 1);
    end

    // position of the byte is taken at the cursor before the move
    pos = tccw_pkg::POS_W'(row) * tccw_pkg::POS_W'(tccw_pkg::COLUMNS)
        + tccw_pkg::POS_W'(col);

    mv.col    = c[tccw_pkg::COL_W-1:0];
    mv.row    = r[tccw_pkg::ROW_W-1:0];
    mv.wr     = printable && (int'(pos) < tccw_pkg::CELLS);
    mv.pos    = tccw_pkg::ADDR_W'(pos);
    mv.scroll = scroll;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tccw_ctrl.sv -----
// Sequencer around the screen store: clearing pass, character writes, cell
// reads, scroll copy and blank fills. Uses tccw_pkg, tccw_ram, tccw_cursor.
`default_nettype none

module tccw_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        item_valid,
  output logic                             item_ready,
  input  wire tccw_pkg::item_t             item,
  input  wire logic [tccw_pkg::ATTR_W-1:0] attr,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output tccw_pkg::result_t                res
);

  tccw_pkg::state_t                state_r, state_nxt;
  logic [tccw_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [tccw_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [tccw_pkg::ADDR_W-1:0]     cnt_r, cnt_nxt;
  logic [tccw_pkg::CHR_W-1:0]      chr_r, chr_nxt;
  logic [tccw_pkg::ATTR_W-1:0]     attr_r, attr_nxt;
  logic                            scr_r, scr_nxt;

  logic                            we;
  logic [tccw_pkg::ADDR_W-1:0]     waddr;
  logic [tccw_pkg::CELL_W-1:0]     wdata;
  logic                            re;
  logic [tccw_pkg::ADDR_W-1:0]     raddr;
  logic [tccw_pkg::CELL_W-1:0]     rdata;
  tccw_pkg::move_t                 mv;

  tccw_cursor u_cursor (
    .col (col_r),
    .row (row_r),
    .chr (item.chr),
    .mv  (mv)
  );

  tccw_ram #(
    .DEPTH (tccw_pkg::CELLS),
    .WIDTH (tccw_pkg::CELL_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (waddr),
    .wr_data (wdata),
    .rd_en   (re),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccw_pkg::S_INIT;
      col_r   <= '0;
      row_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chr_r  <= chr_nxt;
    attr_r <= attr_nxt;
    scr_r  <= scr_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    cnt_nxt    = cnt_r;
    chr_nxt    = chr_r;
    attr_nxt   = attr_r;
    scr_nxt    = scr_r;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    we         = 1'b0;
    waddr      = cnt_r;
    wdata      = {attr, tccw_pkg::CH_SPACE};
    re         = 1'b0;
    raddr      = tccw_pkg::ADDR_W'(item.idx);

    unique case (state_r)
      tccw_pkg::S_INIT: begin
        we    = 1'b1;
        wdata = {tccw_pkg::RESET_ATTR, tccw_pkg::CH_SPACE};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tccw_pkg::S_IDLE;
        end
      end

      tccw_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          chr_nxt   = '0;
          attr_nxt  = '0;
          scr_nxt   = 1'b0;
          state_nxt = tccw_pkg::S_DONE;
          case (item.op)
            tccw_pkg::OP_PUT: begin
              we      = mv.wr;
              waddr   = mv.pos;
              wdata   = {attr, item.chr};
              col_nxt = mv.col;
              row_nxt = mv.row;
              if (mv.scroll) begin
                scr_nxt   = 1'b1;
                cnt_nxt   = '0;
                state_nxt = tccw_pkg::S_COPY;
              end
            end
            tccw_pkg::OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = tccw_pkg::S_FILL;
            end
            tccw_pkg::OP_READ: begin
              if (32'(item.idx) < tccw_pkg::CELLS) begin
                re        = 1'b1;
                state_nxt = tccw_pkg::S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      tccw_pkg::S_READ: begin
        chr_nxt   = rdata[tccw_pkg::CHR_W-1:0];
        attr_nxt  = rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHR_W];
        state_nxt = tccw_pkg::S_DONE;
      end

      // Read cell cnt+COLUMNS, write the previous read to cnt-1. Writes stay
      // below the read pointer, so the copy needs no forwarding.
      tccw_pkg::S_COPY: begin
        re      = (cnt_r != tccw_pkg::ADDR_W'(tccw_pkg::COPY_CELLS));
        raddr   = cnt_r + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
        we      = (cnt_r != '0);
        waddr   = cnt_r - 1'b1;
        wdata   = rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tccw_pkg::ADDR_W'(tccw_pkg::COPY_CELLS)) begin
          cnt_nxt   = cnt_r;   // bottom row fill starts here
          state_nxt = tccw_pkg::S_FILL;
        end
      end

      tccw_pkg::S_FILL: begin
        we      = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tccw_pkg::S_DONE;
        end
      end

      tccw_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = tccw_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tccw_pkg::S_INIT;
      end
    endcase
  end

  assign res.col      = col_r;
  assign res.row      = row_r;
  assign res.chr      = chr_r;
  assign res.attr     = attr_r;
  assign res.scrolled = scr_r;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_character_writer.sv -----
// Top level of the text console character writer: stream ports, colour
// registers and output register. Uses tccw_pkg and tccw_ctrl.
//
//   channel  dir  handshake                  payload
//   in_      in   in_tvalid / in_tready      in_tdata, in_tuser
//   out_     out  out_tvalid / out_tready    out_tdata
//   cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each item is finished before the next is taken, through the single write
// port of the screen store: a clear rewrites all CELLS cells, and a put that
// scrolls copies COPY_CELLS cells up and blanks the bottom row of COLUMNS.
// After reset a clearing pass over all CELLS cells holds in_tready low;
// configuration writes are taken throughout. The next item is taken while a
// result waits in the output register; a stalled output holds the engine.
`default_nettype none

module text_console_character_writer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // [7:0] character, [18:8] cell_index, [23:19] zero
  input  wire logic [tccw_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [1:0] operation
  input  wire logic [tccw_pkg::OP_W-1:0]             in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [6:0] cursor_column, [11:7] cursor_row, [19:12] cell_character,
  // [27:20] cell_attribute, [28] scrolled, [31:29] zero
  output logic [tccw_pkg::OUT_TDATA_W-1:0]           out_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tccw_pkg::CLR_W-1:0]            cfg_data
);

  logic [tccw_pkg::CLR_W-1:0] fg_r, fg_nxt;
  logic [tccw_pkg::CLR_W-1:0] bg_r, bg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tccw_pkg::result_t          out_data_r, out_data_nxt;

  tccw_pkg::item_t            item;
  tccw_pkg::result_t          res;
  logic                       res_valid;
  logic                       res_ready;

  assign item.op  = in_tuser;
  assign item.chr = in_tdata[tccw_pkg::CHR_W-1:0];
  assign item.idx = in_tdata[tccw_pkg::CHR_W +: tccw_pkg::IDX_W];

  tccw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .attr       ({bg_r, fg_r}),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        tccw_pkg::CFG_FG: fg_nxt = cfg_data;
        tccw_pkg::CFG_BG: bg_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= tccw_pkg::RESET_FG;
      bg_r        <= tccw_pkg::RESET_BG;
      out_valid_r <= 1'b0;
    end else begin
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tccw_pkg::OUT_TDATA_W'({out_data_r.scrolled, out_data_r.attr,
                                              out_data_r.chr, out_data_r.row,
                                              out_data_r.col});

  // Cursor stays on the screen
  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_data_r.col) < tccw_pkg::COLUMNS
                 && int'(out_data_r.row) < tccw_pkg::ROWS))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row, no cell data
  a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_data_r.scrolled |->
      (out_data_r.row == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)
       && out_data_r.col == '0 && out_data_r.chr == '0 && out_data_r.attr == '0))
    else $error("scroll result malformed");

  // Reset starts the clearing pass, which takes no items
  a_init_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken during clearing pass");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Testbench for text_console_character_writer: a directed table, then random console traffic.
// Typed rows check against the table, others against a behavioural screen model held here.
// Depends on tccw_pkg and the RTL under rtl/core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int     PHASE_ITEMS = 100;
  localparam int     PHASES      = 6;
  localparam int     HOLD_CYCLES = 400;
  localparam int     IDLE_PCT    = 36;
  localparam int     IDX_MAX     = (1 << tccw_pkg::IDX_W) - 1;
  localparam logic [tccw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // result field offsets in out_tdata
  localparam int ROW_LO  = tccw_pkg::COL_W;
  localparam int CHR_LO  = ROW_LO + tccw_pkg::ROW_W;
  localparam int ATTR_LO = CHR_LO + tccw_pkg::CHR_W;
  localparam int SCR_BIT = ATTR_LO + tccw_pkg::ATTR_W;

  typedef struct {
    logic [tccw_pkg::OP_W-1:0]  op;
    logic [tccw_pkg::CHR_W-1:0] chr;
    logic [tccw_pkg::IDX_W-1:0] idx;
    int                         reps;
    bit                         typed;
    tccw_pkg::result_t          want;
  } stim_row_t;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [tccw_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [tccw_pkg::OP_W-1:0]        in_tuser  = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tccw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [tccw_pkg::CLR_W-1:0]       cfg_data  = '0;

  // screen model
  logic [tccw_pkg::CELL_W-1:0] shadow_cells [tccw_pkg::CELLS];
  int                          cur_col;
  int                          cur_row;
  logic [tccw_pkg::CLR_W-1:0]  fg_colour = tccw_pkg::RESET_FG;
  logic [tccw_pkg::CLR_W-1:0]  bg_colour = tccw_pkg::RESET_BG;

  tccw_pkg::result_t pending_reports [$];
  stim_row_t         stim_table [$];
  int                mismatches = 0;
  longint            cycles     = 0;
  bit                calm       = 1'b0;
  bit                hold_req   = 1'b0;
  int                hold_left  = 0;

  text_console_character_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [tccw_pkg::CELL_W-1:0] blank_word();
    return {bg_colour, fg_colour, tccw_pkg::CH_SPACE};
  endfunction

  // Advances the screen model by one item and returns the cursor report it gives.
  function automatic tccw_pkg::result_t console_step(input logic [tccw_pkg::OP_W-1:0] op,
                                                     input logic [tccw_pkg::CHR_W-1:0] chr,
                                                     input logic [tccw_pkg::IDX_W-1:0] idx);
    tccw_pkg::result_t r;
    r = '0;
    case (op)
      tccw_pkg::OP_PUT: begin
        case (chr)
          tccw_pkg::CH_LF: begin
            cur_col = 0;
            cur_row++;
          end
          tccw_pkg::CH_CR:  cur_col = 0;
          tccw_pkg::CH_TAB: cur_col = (cur_col + tccw_pkg::TAB_STOP)
                                      & ~(tccw_pkg::TAB_STOP - 1);
          tccw_pkg::CH_BS:  if (cur_col > 0) cur_col--;
          default: begin
            shadow_cells[tccw_pkg::ADDR_W'(cur_row * tccw_pkg::COLUMNS + cur_col)] =
              {bg_colour, fg_colour, chr};
            cur_col++;
          end
        endcase
        if (cur_col >= tccw_pkg::COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= tccw_pkg::ROWS) begin
          for (int i = 0; i < tccw_pkg::COPY_CELLS; i++)
            shadow_cells[tccw_pkg::ADDR_W'(i)] =
              shadow_cells[tccw_pkg::ADDR_W'(i + tccw_pkg::COLUMNS)];
          for (int i = tccw_pkg::COPY_CELLS; i < tccw_pkg::CELLS; i++)
            shadow_cells[tccw_pkg::ADDR_W'(i)] = blank_word();
          cur_row    = tccw_pkg::ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      tccw_pkg::OP_CLEAR: begin
        for (int i = 0; i < tccw_pkg::CELLS; i++)
          shadow_cells[tccw_pkg::ADDR_W'(i)] = blank_word();
        cur_col = 0;
        cur_row = 0;
      end
      tccw_pkg::OP_READ: begin
        if (idx < tccw_pkg::CELLS) begin
          r.chr  = shadow_cells[idx][tccw_pkg::CHR_W-1:0];
          r.attr = shadow_cells[idx][tccw_pkg::CELL_W-1:tccw_pkg::CHR_W];
        end
      end
      default: ;
    endcase
    r.col = cur_col[tccw_pkg::COL_W-1:0];
    r.row = cur_row[tccw_pkg::ROW_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic [tccw_pkg::OP_W-1:0] op,
                                  input logic [tccw_pkg::CHR_W-1:0] chr,
                                  input logic [tccw_pkg::IDX_W-1:0] idx, input int reps,
                                  input bit typed = 1'b0,
                                  input tccw_pkg::result_t want = '0);
    stim_row_t s;
    s.op    = op;
    s.chr   = chr;
    s.idx   = idx;
    s.reps  = reps;
    s.typed = typed;
    s.want  = want;
    stim_table.push_back(s);
  endfunction

  // Offers one item, waits for its transfer and queues what it should report.
  task automatic offer_item(input logic [tccw_pkg::OP_W-1:0] op,
                            input logic [tccw_pkg::CHR_W-1:0] chr,
                            input logic [tccw_pkg::IDX_W-1:0] idx, input bit typed = 1'b0,
                            input tccw_pkg::result_t want = '0);
    tccw_pkg::result_t model;
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= tccw_pkg::IN_TDATA_W'({idx, chr});
    do @(posedge clk); while (!in_tready);
    model = console_step(op, chr, idx);
    pending_reports.push_back(typed ? want : model);
  endtask

  task automatic set_colours(input logic [tccw_pkg::CLR_W-1:0] fg,
                             input logic [tccw_pkg::CLR_W-1:0] bg);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= tccw_pkg::CFG_FG;
    cfg_data  <= fg;
    do @(posedge clk); while (!cfg_ready);
    fg_colour = fg;
    @(negedge clk);
    cfg_index <= tccw_pkg::CFG_BG;
    cfg_data  <= bg;
    do @(posedge clk); while (!cfg_ready);
    bg_colour = bg;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering and lets the engine drain.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly text with line breaks, so the cursor reaches the bottom and scrolls;
  // reads favour the rows around the cursor.
  task automatic random_item();
    int                         roll;
    int                         rd_row;
    logic [tccw_pkg::CHR_W-1:0] ch;
    logic [tccw_pkg::IDX_W-1:0] idx;
    roll = $urandom_range(999);
    ch   = tccw_pkg::CHR_W'($urandom_range(255));
    idx  = tccw_pkg::IDX_W'($urandom_range(IDX_MAX));
    if (roll < 520) begin
      offer_item(tccw_pkg::OP_PUT, ch, idx);
    end else if (roll < 620) begin
      offer_item(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, idx);
    end else if (roll < 700) begin
      case ($urandom_range(2))
        0:       ch = tccw_pkg::CH_CR;
        1:       ch = tccw_pkg::CH_TAB;
        default: ch = tccw_pkg::CH_BS;
      endcase
      offer_item(tccw_pkg::OP_PUT, ch, idx);
    end else if (roll < 705) begin
      offer_item(tccw_pkg::OP_CLEAR, ch, idx);
    end else if (roll < 725) begin
      offer_item(OP_UNUSED, ch, idx);
    end else begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        rd_row = (cur_row > 0 && $urandom_range(1)) ? cur_row - 1 : cur_row;
        idx    = tccw_pkg::IDX_W'(rd_row * tccw_pkg::COLUMNS
                                  + $urandom_range(tccw_pkg::COLUMNS - 1));
      end else if (roll < 60) begin
        idx = tccw_pkg::IDX_W'($urandom_range(IDX_MAX, tccw_pkg::CELLS));
      end
      offer_item(tccw_pkg::OP_READ, ch, idx);
    end
  endtask

  // sink side: random stalls, and a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    tccw_pkg::result_t got;
    tccw_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.col      = out_tdata[ROW_LO-1:0];
      got.row      = out_tdata[CHR_LO-1:ROW_LO];
      got.chr      = out_tdata[ATTR_LO-1:CHR_LO];
      got.attr     = out_tdata[SCR_BIT-1:ATTR_LO];
      got.scrolled = out_tdata[SCR_BIT];
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result col %0d row %0d chr %h attr %h scr %b",
                   $realtime, got.col, got.row, got.chr, got.attr, got.scrolled);
      end else begin
        want = pending_reports.pop_front();
        if (got.col !== want.col || got.row !== want.row || got.chr !== want.chr ||
            got.attr !== want.attr || got.scrolled !== want.scrolled) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: exp col %0d row %0d chr %h attr %h scr %b, ",
                      "got col %0d row %0d chr %h attr %h scr %b"},
                     $realtime, want.col, want.row, want.chr, want.attr, want.scrolled,
                     got.col, got.row, got.chr, got.attr, got.scrolled);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_console_character_writer: mismatch");
      $finish;
    end
  end

  initial begin
    logic [tccw_pkg::CLR_W-1:0] fg;
    logic [tccw_pkg::CLR_W-1:0] bg;
    foreach (shadow_cells[i]) shadow_cells[i] = {tccw_pkg::RESET_ATTR, tccw_pkg::CH_SPACE};
    cur_col = 0;
    cur_row = 0;

    // reset state, extremes of the index, out-of-range reads, odd bytes
    add_row(tccw_pkg::OP_READ, 8'h00, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h20, 8'h0F, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'hFF, tccw_pkg::IDX_W'(tccw_pkg::CELLS - 1), 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h20, 8'h0F, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'h00, tccw_pkg::IDX_W'(tccw_pkg::CELLS), 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'h00, tccw_pkg::IDX_W'(IDX_MAX), 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(OP_UNUSED, 8'hFF, tccw_pkg::IDX_W'(IDX_MAX), 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, 8'h41, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd1, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, 8'h00, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd2, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, 8'hFF, tccw_pkg::IDX_W'(IDX_MAX), 1, 1'b1,
            tccw_pkg::result_t'{7'd3, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'h00, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd3, 5'd0, 8'h41, 8'h0F, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'h00, 11'd1, 1, 1'b1,
            tccw_pkg::result_t'{7'd3, 5'd0, 8'h00, 8'h0F, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'h00, 11'd2, 1, 1'b1,
            tccw_pkg::result_t'{7'd3, 5'd0, 8'hFF, 8'h0F, 1'b0});
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd2, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd4, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd8, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_CR, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h00, 8'h00, 1'b0});
    // backspace at column 0 stays put
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_BS, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd1, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_CLEAR, 8'h5A, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h00, 8'h00, 1'b0});
    add_row(tccw_pkg::OP_READ, 8'h00, 11'd0, 1, 1'b1,
            tccw_pkg::result_t'{7'd0, 5'd0, 8'h20, 8'h0F, 1'b0});
    // tab that runs off the right edge, then down to the bottom and scroll
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 11'd0,
            tccw_pkg::COLUMNS / tccw_pkg::TAB_STOP - 1);
    add_row(tccw_pkg::OP_PUT, 8'h7A, 11'd0, tccw_pkg::TAB_STOP - 1);
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB, 11'd0, 1);
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 11'd0, tccw_pkg::ROWS - 2);
    add_row(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 11'd0, 1);
    add_row(tccw_pkg::OP_PUT, 8'h71, 11'd0, tccw_pkg::COLUMNS);
    add_row(tccw_pkg::OP_READ, 8'h00,
            tccw_pkg::IDX_W'((tccw_pkg::ROWS - 2) * tccw_pkg::COLUMNS + 5), 1);
    add_row(tccw_pkg::OP_READ, 8'h00, tccw_pkg::IDX_W'(tccw_pkg::COPY_CELLS), 1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    do @(posedge clk); while (!in_tready);

    set_colours(tccw_pkg::RESET_FG, tccw_pkg::RESET_BG);
    foreach (stim_table[k])
      repeat (stim_table[k].reps)
        offer_item(stim_table[k].op, stim_table[k].chr, stim_table[k].idx,
                   stim_table[k].typed, stim_table[k].want);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin fg = 4'h0; bg = 4'h0; end
        1:       begin fg = 4'hF; bg = 4'hF; end
        2:       begin fg = 4'h5; bg = 4'hA; end
        3:       begin fg = 4'h0; bg = 4'hF; end
        4:       begin fg = 4'hF; bg = 4'h0; end
        default: begin
          fg = tccw_pkg::CLR_W'($urandom_range(15));
          bg = tccw_pkg::CLR_W'($urandom_range(15));
        end
      endcase
      set_colours(fg, bg);
      calm = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 5 && (ph == 1 || ph == 4)) hold_req = 1'b1;
        random_item();
      end
      settle();
    end
    calm = 1'b0;
    repeat (50) @(posedge clk);

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("text_console_character_writer: match");
    end else begin
      $display("text_console_character_writer: mismatch");
    end
    $finish;
  end

endmodule

// ----- text_console_character_writer.f -----
rtl/core/tccw_pkg.sv
rtl/core/tccw_ram.sv
rtl/core/tccw_cursor.sv
rtl/core/tccw_ctrl.sv
rtl/core/text_console_character_writer.sv
test/tb.sv
